// ----- hdl/bhpq_pkg.sv -----
package bhpq_pkg;

    localparam int CAPACITY_DEFAULT  = 256;
    localparam int KEY_WIDTH_DEFAULT = 32;

    localparam int KEY_FIELD_W   = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 9;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic REG_HEAP_ORDER     = 1'b0;
    localparam logic REG_COMPARE_SIGNED = 1'b1;

    typedef struct packed {
        logic                   operation;
        logic [KEY_FIELD_W-1:0] key_in;
    } cmd_item_t;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0]   key_out;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } rsp_item_t;

endpackage

// ----- hdl/bhpq_ram.sv -----
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// ----- hdl/binary_heap_priority_queue_unit.sv -----
// Binary heap priority queue with CAPACITY keys held in a two-read, one-write RAM and one
// shared key comparator stepped by a small sequencer. Each level of a sift costs a RAM read,
// whose data come back registered, and a compare; on the way down a further step picks the
// better of the two children. An enqueue climbs while its key outranks the parent, moving
// each parent down, then writes the key in a final step; into an empty queue it writes the
// key at once. A dequeue reads the root and the last entry, sinks the moved key level by
// level and writes it in a final step, or skips the sift when it empties the queue. Either
// loads its result once the output register is free. A rejected item (full or empty) gives
// its result in the cycle after acceptance. The queue takes no new item while one is in
// progress or while a result waits stalled in the output register; the next item can be
// accepted at the edge that takes the result.
module binary_heap_priority_queue_unit #(
    parameter int CAPACITY  = bhpq_pkg::CAPACITY_DEFAULT,
    parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  bhpq_pkg::cmd_item_t           cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output bhpq_pkg::rsp_item_t           rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bhpq_pkg::PADDR_W-1:0]  paddr,
    input  logic [bhpq_pkg::PDATA_W-1:0]  pwdata,
    output logic [bhpq_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int IW = $clog2(CAPACITY);
    localparam int XW = IW + 2;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = KEY_WIDTH;

    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [bhpq_pkg::COUNT_FIELD_W-1:0] CAP_FIELD =
        bhpq_pkg::COUNT_FIELD_W'(CAPACITY);
    localparam logic [KW-1:0] SIGN_BIT = KW'(1) << (KW - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP_RD  = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_DQ_RD  = 4'd3;
    localparam logic [3:0] S_DQ_LD  = 4'd4;
    localparam logic [3:0] S_DN_RD  = 4'd5;
    localparam logic [3:0] S_DN_SEL = 4'd6;
    localparam logic [3:0] S_DN_CMP = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] best_pos_reg, best_pos_next;
    logic [KW-1:0] hold_key_reg, hold_key_next;
    logic [KW-1:0] best_key_reg, best_key_next;
    logic [KW-1:0] top_key_reg, top_key_next;
    logic          rsp_valid_reg, rsp_valid_next;
    bhpq_pkg::rsp_item_t rsp_reg, rsp_next;
    logic          heap_order_reg;
    logic          compare_signed_reg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [KW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr_a;
    logic [IW-1:0] ram_raddr_b;
    logic [KW-1:0] ram_rdata_a;
    logic [KW-1:0] ram_rdata_b;

    logic [KW-1:0] cmp_a;
    logic [KW-1:0] cmp_b;
    logic [KW-1:0] cmp_a_x;
    logic [KW-1:0] cmp_b_x;
    logic          cmp_above;

    logic          cmd_accept;
    logic          rsp_free;
    logic          cfg_write;
    logic [IW-1:0] parent;
    logic [XW-1:0] left_x;
    logic [XW-1:0] right_x;
    logic [XW-1:0] count_x;

    bhpq_ram #(
        .WIDTH (KW),
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            bhpq_pkg::REG_HEAP_ORDER:     prdata[0] = heap_order_reg;
            bhpq_pkg::REG_COMPARE_SIGNED: prdata[0] = compare_signed_reg;
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_order_reg     <= 1'b0;
            compare_signed_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == bhpq_pkg::REG_HEAP_ORDER)
            begin
                heap_order_reg <= pwdata[0];
            end
            else
            begin
                compare_signed_reg <= pwdata[0];
            end
        end
    end

    // The one key comparator: true when cmp_a must sit strictly above cmp_b.
    always_comb
    begin
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = hold_key_reg;
                cmp_b = ram_rdata_a;
            end
            S_DN_SEL:
            begin
                cmp_a = ram_rdata_b;
                cmp_b = ram_rdata_a;
            end
            default:
            begin
                cmp_a = best_key_reg;
                cmp_b = hold_key_reg;
            end
        endcase
        cmp_a_x   = cmp_a ^ (compare_signed_reg ? SIGN_BIT : '0);
        cmp_b_x   = cmp_b ^ (compare_signed_reg ? SIGN_BIT : '0);
        cmp_above = heap_order_reg ? (cmp_a_x > cmp_b_x) : (cmp_a_x < cmp_b_x);
    end

    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall  = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign parent  = (pos_reg - IW'(1)) >> 1;
    assign left_x  = {1'b0, pos_reg, 1'b1};
    assign right_x = left_x + XW'(1);
    assign count_x = XW'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        best_pos_next  = best_pos_reg;
        hold_key_next  = hold_key_reg;
        best_key_next  = best_key_reg;
        top_key_next   = top_key_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = hold_key_reg;
        ram_raddr_a    = '0;
        ram_raddr_b    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    if (cmd.operation == bhpq_pkg::OP_ENQUEUE)
                    begin
                        if (count_reg == CAP_COUNT)
                        begin
                            rsp_valid_next       = 1'b1;
                            rsp_next.key_out     = '0;
                            rsp_next.status      = bhpq_pkg::ST_FULL;
                            rsp_next.entry_count = bhpq_pkg::COUNT_FIELD_W'(count_reg);
                        end
                        else
                        begin
                            hold_key_next = KW'(cmd.key_in);
                            top_key_next  = '0;
                            pos_next      = IW'(count_reg);
                            count_next    = count_reg + CW'(1);
                            state_next    = (count_reg == '0) ? S_FIN : S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_valid_next       = 1'b1;
                            rsp_next.key_out     = '0;
                            rsp_next.status      = bhpq_pkg::ST_EMPTY;
                            rsp_next.entry_count = '0;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_DQ_RD;
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                ram_raddr_a = parent;
                state_next  = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (cmp_above)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata_a;
                    pos_next   = parent;
                    state_next = (parent == '0) ? S_FIN : S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DQ_RD:
            begin
                ram_raddr_a = '0;
                ram_raddr_b = IW'(count_reg);
                state_next  = S_DQ_LD;
            end
            S_DQ_LD:
            begin
                top_key_next  = ram_rdata_a;
                hold_key_next = ram_rdata_b;
                pos_next      = '0;
                state_next    = (count_reg == '0) ? S_DONE : S_DN_RD;
            end
            S_DN_RD:
            begin
                ram_raddr_a = IW'(left_x);
                ram_raddr_b = IW'(right_x);
                state_next  = (left_x >= count_x) ? S_FIN : S_DN_SEL;
            end
            S_DN_SEL:
            begin
                if ((right_x < count_x) && cmp_above)
                begin
                    best_pos_next = IW'(right_x);
                    best_key_next = ram_rdata_b;
                end
                else
                begin
                    best_pos_next = IW'(left_x);
                    best_key_next = ram_rdata_a;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (cmp_above)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = best_key_reg;
                    pos_next   = best_pos_reg;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                ram_we     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.key_out     = bhpq_pkg::KEY_FIELD_W'(top_key_reg);
                    rsp_next.status      = bhpq_pkg::ST_OK;
                    rsp_next.entry_count = bhpq_pkg::COUNT_FIELD_W'(count_reg);
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        best_pos_reg <= best_pos_next;
        hold_key_reg <= hold_key_next;
        best_key_reg <= best_key_next;
        top_key_reg  <= top_key_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("Entry count exceeds capacity.");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == bhpq_pkg::ST_EMPTY) |-> rsp.entry_count == '0)
        else $error("Empty status with a nonzero entry count.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == bhpq_pkg::ST_FULL) |-> rsp.entry_count == CAP_FIELD)
        else $error("Full status below capacity.");

    a_reject_key: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != bhpq_pkg::ST_OK) |-> rsp.key_out == '0)
        else $error("Rejected item carries a key.");
`endif

endmodule

// ----- tb/sv/binary_heap_priority_queue_unit_test.sv -----
`timescale 1ns / 1ps

module binary_heap_priority_queue_unit_test;

    localparam int HEAP_SLOTS = bhpq_pkg::CAPACITY_DEFAULT;
    localparam int KW = bhpq_pkg::KEY_FIELD_W;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [KW-1:0] SIGN_BIT = {1'b1, {(KW-1){1'b0}}};

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    bhpq_pkg::cmd_item_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    bhpq_pkg::rsp_item_t rsp;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bhpq_pkg::PADDR_W-1:0] paddr;
    logic [bhpq_pkg::PDATA_W-1:0] pwdata;
    logic [bhpq_pkg::PDATA_W-1:0] prdata;
    logic pready;

    logic [KW-1:0] shadow_keys [HEAP_SLOTS];
    int shadow_count;
    logic heap_is_max;
    logic keys_signed;

    bhpq_pkg::rsp_item_t pending_results[$];
    int error_count;
    int checked_count;
    int enqueue_count;
    int dequeue_count;
    int full_count;
    int empty_count;
    int setting_count;
    bit tx_idle_en;
    bit rx_idle_en;
    bit long_hold_req;

    binary_heap_priority_queue_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 clk = ~clk;

    function automatic bit outranks(input logic [KW-1:0] a, input logic [KW-1:0] b);
        logic [KW-1:0] x;
        logic [KW-1:0] y;
        x = keys_signed ? (a ^ SIGN_BIT) : a;
        y = keys_signed ? (b ^ SIGN_BIT) : b;
        return heap_is_max ? (x > y) : (x < y);
    endfunction

    function automatic void swap_keys(input int i, input int j);
        logic [KW-1:0] t;
        t = shadow_keys[i];
        shadow_keys[i] = shadow_keys[j];
        shadow_keys[j] = t;
    endfunction

    function automatic bhpq_pkg::rsp_item_t apply_heap_op(input bhpq_pkg::cmd_item_t c);
        bhpq_pkg::rsp_item_t r;
        int pos;
        int parent;
        int lft;
        int best;
        r.key_out = '0;
        r.status = bhpq_pkg::ST_OK;
        if (c.operation == bhpq_pkg::OP_ENQUEUE)
        begin
            enqueue_count++;
            if (shadow_count >= HEAP_SLOTS)
            begin
                r.status = bhpq_pkg::ST_FULL;
                full_count++;
            end
            else
            begin
                shadow_keys[shadow_count] = c.key_in;
                pos = shadow_count;
                while (pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (!outranks(shadow_keys[pos], shadow_keys[parent]))
                        break;
                    swap_keys(pos, parent);
                    pos = parent;
                end
                shadow_count++;
            end
        end
        else
        begin
            dequeue_count++;
            if (shadow_count == 0)
            begin
                r.status = bhpq_pkg::ST_EMPTY;
                empty_count++;
            end
            else
            begin
                r.key_out = shadow_keys[0];
                shadow_count--;
                shadow_keys[0] = shadow_keys[shadow_count];
                pos = 0;
                forever
                begin
                    lft = 2 * pos + 1;
                    if (lft >= shadow_count)
                        break;
                    best = lft;
                    if (lft + 1 < shadow_count &&
                        outranks(shadow_keys[lft + 1], shadow_keys[lft]))
                        best = lft + 1;
                    if (!outranks(shadow_keys[best], shadow_keys[pos]))
                        break;
                    swap_keys(pos, best);
                    pos = best;
                end
            end
        end
        r.entry_count = shadow_count[bhpq_pkg::COUNT_FIELD_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KW-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return SIGN_BIT;
                    default: return ~SIGN_BIT;
                endcase
            end
            1: return $urandom_range(0, 3);
            2: return SIGN_BIT + $urandom_range(0, 3) - 2;
            3: return '1 - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [KW-1:0] key);
        bhpq_pkg::cmd_item_t item;
        int gap;
        item.operation = op;
        item.key_in = key;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= item;
        do @(posedge clk); while (cmd_stall);
        pending_results.push_back(apply_heap_op(item));
    endtask

    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        logic [bhpq_pkg::PDATA_W-1:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= bhpq_pkg::PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == bhpq_pkg::REG_HEAP_ORDER)
            heap_is_max = val;
        else
            keys_signed = val;
        if (readback !== bhpq_pkg::PDATA_W'(val))
        begin
            $display("%0t: register %0d readback expected %h actual %h",
                     $time, idx, bhpq_pkg::PDATA_W'(val), readback);
            error_count++;
        end
    endtask

    task automatic set_config(input logic order_max, input logic use_signed);
        wait_idle();
        write_reg(bhpq_pkg::REG_HEAP_ORDER, order_max);
        @(posedge clk);
        write_reg(bhpq_pkg::REG_COMPARE_SIGNED, use_signed);
        setting_count++;
    endtask

    task automatic run_random(input int n, input int enq_pct);
        for (int i = 0; i < n; i++)
            send_item(($urandom_range(0, 99) < enq_pct) ? bhpq_pkg::OP_ENQUEUE
                                                        : bhpq_pkg::OP_DEQUEUE,
                      pick_key());
    endtask

    task automatic test_directed_corners();
        set_config(1'b0, 1'b0);
        send_item(bhpq_pkg::OP_DEQUEUE, $urandom);
        send_item(bhpq_pkg::OP_ENQUEUE, '1);
        send_item(bhpq_pkg::OP_ENQUEUE, '0);
        send_item(bhpq_pkg::OP_ENQUEUE, SIGN_BIT);
        send_item(bhpq_pkg::OP_ENQUEUE, ~SIGN_BIT);
        send_item(bhpq_pkg::OP_ENQUEUE, 32'd5);
        send_item(bhpq_pkg::OP_ENQUEUE, 32'd5);
        send_item(bhpq_pkg::OP_ENQUEUE, 32'd5);
        send_item(bhpq_pkg::OP_ENQUEUE, 32'd1);
        for (int i = 0; i < 9; i++)
            send_item(bhpq_pkg::OP_DEQUEUE, $urandom);
    endtask

    task automatic test_fill_and_drain();
        set_config(1'b1, 1'b1);
        for (int i = 0; i < HEAP_SLOTS; i++)
            send_item(bhpq_pkg::OP_ENQUEUE, pick_key());
        send_item(bhpq_pkg::OP_ENQUEUE, pick_key());
        send_item(bhpq_pkg::OP_ENQUEUE, '1);
        for (int i = 0; i < HEAP_SLOTS + 2; i++)
            send_item(bhpq_pkg::OP_DEQUEUE, $urandom);
    endtask

    task automatic test_output_backpressure();
        set_config(1'b0, 1'b1);
        tx_idle_en = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item((i % 4 == 3) ? bhpq_pkg::OP_DEQUEUE : bhpq_pkg::OP_ENQUEUE, pick_key());
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_settings();
        set_config(1'b1, 1'b0);
        run_random(170, 65);
        set_config(1'b0, 1'b0);
        rx_idle_en = 1'b0;
        run_random(170, 50);
        rx_idle_en = 1'b1;
        set_config(1'b1, 1'b1);
        tx_idle_en = 1'b0;
        run_random(170, 55);
        tx_idle_en = 1'b1;
        set_config(1'b0, 1'b1);
        run_random(170, 35);
    endtask

    always @(posedge clk)
    begin
        bhpq_pkg::rsp_item_t exp;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            checked_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual key %h status %0d count %0d",
                         $time, rsp.key_out, rsp.status, rsp.entry_count);
                error_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (rsp.key_out !== exp.key_out)
                begin
                    $display("%0t: key_out expected %h actual %h",
                             $time, exp.key_out, rsp.key_out);
                    error_count++;
                end
                if (rsp.status !== exp.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp.status, rsp.status);
                    error_count++;
                end
                if (rsp.entry_count !== exp.entry_count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, exp.entry_count, rsp.entry_count);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 99) < 25)
            begin
                hold_left = pick_gap();
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #10ms;
        $display("binary_heap_priority_queue_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        shadow_count = 0;
        heap_is_max = 1'b0;
        keys_signed = 1'b0;
        error_count = 0;
        checked_count = 0;
        enqueue_count = 0;
        dequeue_count = 0;
        full_count = 0;
        empty_count = 0;
        setting_count = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        long_hold_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_fill_and_drain();
        test_output_backpressure();
        test_random_settings();
        wait_idle();

        $display("Checked %0d results: %0d enqueues (%0d full), %0d dequeues (%0d empty).",
                 checked_count, enqueue_count, full_count, dequeue_count, empty_count);
        $display("Ran under %0d order and compare settings with random gaps and a long output hold.",
                 setting_count);
        if (error_count == 0)
            $display("binary_heap_priority_queue_unit_test OK");
        else
            $display("binary_heap_priority_queue_unit_test NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bhpq_pkg.sv
hdl/bhpq_ram.sv
hdl/binary_heap_priority_queue_unit.sv
tb/sv/binary_heap_priority_queue_unit_test.sv
